/* hw/rtl/u8u16_pkg.sv */
// u8u16_pkg: shared types and constants for the UTF-8 to UTF-16 transcoder.
// No dependencies.
package u8u16_pkg;

  localparam int MaxResults = 3;
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);

  localparam logic [20:0] MaxPoint    = 21'h10FFFF;
  localparam logic [20:0] SurrLow     = 21'h00D800;
  localparam logic [20:0] SurrHigh    = 21'h00DFFF;
  localparam logic [20:0] PlaneOne    = 21'h010000;
  localparam logic [15:0] HighSurBase = 16'hD800;
  localparam logic [15:0] LowSurBase  = 16'hDC00;
  localparam logic [16:0] MinTwoByte  = 17'h00080;
  localparam logic [16:0] MinThree    = 17'h00800;
  localparam logic [16:0] MinFour     = 17'h10000;

  typedef struct packed {
    logic [15:0] unit_out;
    logic        end_of_string;
  } unit_item_t;

  // results of one request, slot 0 first
  typedef struct packed {
    unit_item_t [MaxResults-1:0] items;
    logic [1:0]                  count;
  } dec_out_t;

endpackage

/* hw/rtl/u8u16_if.sv */
// Channel interfaces: byte requests in, UTF-16 units out.
// No dependencies.
interface u8u16_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       final_byte;
  modport source (output valid, byte_in, final_byte, input ready);
  modport sink (input valid, byte_in, final_byte, output ready);
endinterface

interface u8u16_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] unit_out;
  logic        end_of_string;
  modport source (output valid, unit_out, end_of_string, input ready);
  modport sink (input valid, unit_out, end_of_string, output ready);
endinterface

/* hw/rtl/u8u16_decoder.sv */
// u8u16_decoder: decode state and per-byte result logic.
// Depends on u8u16_pkg and u8u16_byte_if.
module u8u16_decoder
  import u8u16_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  u8u16_byte_if.sink    in_ch,
  input  logic          room,
  output dec_out_t      res
);

  logic [20:0] partial_point, partial_point_next;
  logic [1:0]  bytes_owed, bytes_owed_next;
  logic [16:0] minimum_point, minimum_point_next;
  logic        halted, halted_next;

  logic        accept;
  logic [7:0]  b;
  logic        cont;
  logic [20:0] cp;
  logic [20:0] cp_off;
  logic        bad;

  assign in_ch.ready = room & ~rst;
  assign accept      = in_ch.valid & room & ~rst;
  assign b           = in_ch.byte_in;
  assign cont        = (b[7:6] == 2'b10);
  assign cp          = {partial_point[14:0], b[5:0]};
  assign cp_off      = cp - PlaneOne;
  assign bad         = (cp < {4'b0, minimum_point}) || (cp > MaxPoint) ||
                       (cp inside {[SurrLow:SurrHigh]});

  always_comb begin
    res                = '0;
    partial_point_next = partial_point;
    bytes_owed_next    = bytes_owed;
    minimum_point_next = minimum_point;
    halted_next        = halted;
    if (accept) begin
      if (!halted) begin
        if (bytes_owed == 2'd0) begin
          if (!b[7]) begin
            res.items[0] = '{unit_out: {8'b0, b}, end_of_string: 1'b0};
            res.count    = 2'd1;
          end else if (b[7:5] == 3'b110) begin
            partial_point_next = {16'b0, b[4:0]};
            bytes_owed_next    = 2'd1;
            minimum_point_next = MinTwoByte;
          end else if (b[7:4] == 4'b1110) begin
            partial_point_next = {17'b0, b[3:0]};
            bytes_owed_next    = 2'd2;
            minimum_point_next = MinThree;
          end else if (b[7:3] == 5'b11110) begin
            partial_point_next = {18'b0, b[2:0]};
            bytes_owed_next    = 2'd3;
            minimum_point_next = MinFour;
          end else begin
            halted_next = 1'b1;
          end
        end else if (!cont) begin
          halted_next        = 1'b1;
          bytes_owed_next    = 2'd0;
          partial_point_next = '0;
          minimum_point_next = '0;
        end else begin
          partial_point_next = cp;
          bytes_owed_next    = bytes_owed - 2'd1;
          if (bytes_owed == 2'd1) begin
            partial_point_next = '0;
            minimum_point_next = '0;
            if (bad) begin
              halted_next = 1'b1;
            end else if (cp >= PlaneOne) begin
              res.items[0] = '{unit_out: HighSurBase + {6'b0, cp_off[19:10]},
                               end_of_string: 1'b0};
              res.items[1] = '{unit_out: LowSurBase | {6'b0, cp_off[9:0]},
                               end_of_string: 1'b0};
              res.count    = 2'd2;
            end else begin
              res.items[0] = '{unit_out: cp[15:0], end_of_string: 1'b0};
              res.count    = 2'd1;
            end
          end
        end
      end
      if (in_ch.final_byte) begin
        res.items[res.count] = '{unit_out: 16'h0000, end_of_string: 1'b1};
        res.count            = res.count + 2'd1;
        partial_point_next   = '0;
        bytes_owed_next      = 2'd0;
        minimum_point_next   = '0;
        halted_next          = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_point <= '0;
      bytes_owed    <= '0;
      minimum_point <= '0;
      halted        <= 1'b0;
    end else begin
      partial_point <= partial_point_next;
      bytes_owed    <= bytes_owed_next;
      minimum_point <= minimum_point_next;
      halted        <= halted_next;
    end
  end

endmodule

/* hw/rtl/u8u16_queue.sv */
// u8u16_queue: result queue, takes up to three units a cycle, gives one while out_ch is ready.
// Depends on u8u16_pkg and u8u16_unit_if.
module u8u16_queue
  import u8u16_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  dec_out_t      wr,
  output logic          room,
  u8u16_unit_if.source  out_ch
);

  localparam int CountW = $clog2(QueueDepth + 1);

  unit_item_t           mem [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr, rd_ptr;
  logic [CountW-1:0]    count, count_next;
  logic                 pop;

  assign out_ch.valid         = (count != '0);
  assign out_ch.unit_out      = mem[rd_ptr].unit_out;
  assign out_ch.end_of_string = mem[rd_ptr].end_of_string;
  assign pop                  = out_ch.valid & out_ch.ready;
  // space for a full three-unit request
  assign room = (count <= CountW'(QueueDepth - MaxResults));
  assign count_next = count + CountW'(wr.count) - CountW'(pop);

  always_ff @(posedge clk) begin
    for (int i = 0; i < MaxResults; i++) begin
      if (2'(i) < wr.count) begin
        mem[wr_ptr + QueuePtrW'(i)] <= wr.items[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QueuePtrW'(wr.count);
      rd_ptr <= rd_ptr + QueuePtrW'(pop);
      count  <= count_next;
    end
  end

endmodule

/* hw/rtl/utf8_to_utf16_transcoder.sv */
// utf8_to_utf16_transcoder: top level, UTF-8 bytes in, UTF-16 units out.
// Depends on u8u16_pkg, u8u16_if, u8u16_decoder and u8u16_queue.
//
//   channel    dir  payload                          handshake
//   byte_chan  in   byte_in[7:0], final_byte         valid/ready
//   unit_chan  out  unit_out[15:0], end_of_string    valid/ready
//
// A byte is decoded in the cycle it is taken; its units enter a four-deep
// queue and appear from the next cycle, one unit per cycle while unit_chan is ready.
// One byte per cycle while each byte gives at most one unit and unit_chan is ready;
// surrogate pairs and terminators put extra units into the queue and so slow the bytes.
// byte_chan.ready is low while the queue cannot take three units.
// rst is synchronous: it empties the queue and clears the decode state.
module utf8_to_utf16_transcoder
  import u8u16_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  u8u16_byte_if.sink    byte_chan,
  u8u16_unit_if.source  unit_chan
);

  dec_out_t res;
  logic     room;

  u8u16_decoder u_dec (
    .clk   (clk),
    .rst   (rst),
    .in_ch (byte_chan),
    .room  (room),
    .res   (res)
  );

  u8u16_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (res),
    .room   (room),
    .out_ch (unit_chan)
  );

endmodule

/* tb/sv/tb_top.sv */
// tb_top: self-checking bench for utf8_to_utf16_transcoder, byte requests in, UTF-16 units out.
// Depends on u8u16_pkg, u8u16_if and the transcoder RTL; a small scoreboard class predicts units.
module tb_top
  import u8u16_pkg::*;
();

  class transcode_scoreboard;
    logic [20:0] partial_point;
    logic [1:0]  bytes_owed;
    logic [16:0] minimum_point;
    bit          halted;
    unit_item_t  expected_units[$];
    int          errors;

    function new();
      clear_state();
      errors = 0;
    endfunction

    function void clear_state();
      partial_point = '0;
      bytes_owed    = '0;
      minimum_point = '0;
      halted        = 1'b0;
    endfunction

    function void add_unit(logic [15:0] unit, logic eos);
      unit_item_t item;
      item.unit_out      = unit;
      item.end_of_string = eos;
      expected_units.insert(expected_units.size(), item);
    endfunction

    function void note_byte(logic [7:0] b, logic fin);
      logic [20:0] point;
      if (!halted) begin
        if (bytes_owed == 2'd0) begin
          if (!b[7]) begin
            add_unit({8'h00, b}, 1'b0);
          end else if (b[7:5] == 3'b110) begin
            partial_point = {16'd0, b[4:0]};
            bytes_owed    = 2'd1;
            minimum_point = MinTwoByte;
          end else if (b[7:4] == 4'b1110) begin
            partial_point = {17'd0, b[3:0]};
            bytes_owed    = 2'd2;
            minimum_point = MinThree;
          end else if (b[7:3] == 5'b11110) begin
            partial_point = {18'd0, b[2:0]};
            bytes_owed    = 2'd3;
            minimum_point = MinFour;
          end else begin
            halted = 1'b1;
          end
        end else if (b[7:6] != 2'b10) begin
          halted        = 1'b1;
          bytes_owed    = '0;
          partial_point = '0;
          minimum_point = '0;
        end else begin
          partial_point = {partial_point[14:0], b[5:0]};
          bytes_owed    = bytes_owed - 2'd1;
          if (bytes_owed == 2'd0) begin
            point = partial_point;
            if (point < {4'd0, minimum_point} || point > MaxPoint ||
                (point >= SurrLow && point <= SurrHigh)) begin
              halted = 1'b1;
            end else if (point >= PlaneOne) begin
              point = point - PlaneOne;
              add_unit(HighSurBase + {6'd0, point[19:10]}, 1'b0);
              add_unit(LowSurBase + {6'd0, point[9:0]}, 1'b0);
            end else begin
              add_unit(point[15:0], 1'b0);
            end
            partial_point = '0;
            minimum_point = '0;
          end
        end
      end
      if (fin) begin
        add_unit(16'h0000, 1'b1);
        clear_state();
      end
    endfunction

    function void check_unit(logic [15:0] unit, logic eos);
      unit_item_t want;
      if (expected_units.size() == 0) begin
        $display("%0t: unexpected unit, expected none, got unit_out %h end_of_string %b",
                 $time, unit, eos);
        errors++;
      end else begin
        want = expected_units.pop_front();
        if (want.unit_out !== unit) begin
          $display("%0t: unit_out expected %h got %h", $time, want.unit_out, unit);
          errors++;
        end
        if (want.end_of_string !== eos) begin
          $display("%0t: end_of_string expected %b got %b", $time, want.end_of_string, eos);
          errors++;
        end
      end
    endfunction
  endclass

  // {final_byte, byte_in}
  localparam logic [8:0] DirectedSeq [27] = '{
    9'h07F, 9'h0C2, 9'h080, 9'h0EF, 9'h0BF, 9'h0BF, 9'h0F4, 9'h08F, 9'h0BF, 9'h1BF,
    9'h100,
    9'h0C0, 9'h080, 9'h141,
    9'h0ED, 9'h0A0, 9'h180,
    9'h0F4, 9'h090, 9'h080, 9'h180,
    9'h180,
    9'h1FF,
    9'h0E2, 9'h141,
    9'h0E2, 9'h182
  };

  logic clk = 1'b0;
  logic rst;

  u8u16_byte_if byte_chan ();
  u8u16_unit_if unit_chan ();

  utf8_to_utf16_transcoder u_dut (
    .clk       (clk),
    .rst       (rst),
    .byte_chan (byte_chan),
    .unit_chan (unit_chan)
  );

  transcode_scoreboard sb;
  logic [7:0]          utf8_buf[$];
  int                  live_bytes = 0;
  bit                  sender_gaps = 1'b1;
  bit                  receiver_gaps = 1'b1;
  int                  hold_requests = 0;

  always #5 clk = ~clk;

  task automatic push_byte(input logic [7:0] b, input logic fin);
    @(negedge clk);
    while (sender_gaps && $urandom_range(0, 99) < 33) begin
      byte_chan.valid <= 1'b0;
      @(negedge clk);
    end
    byte_chan.valid      <= 1'b1;
    byte_chan.byte_in    <= b;
    byte_chan.final_byte <= fin;
    @(posedge clk);
    while (!byte_chan.ready) @(posedge clk);
    live_bytes++;
    sb.note_byte(b, fin);
  endtask

  task automatic wait_drain(input int limit);
    int cycles;
    cycles = 0;
    @(negedge clk);
    byte_chan.valid <= 1'b0;
    while (sb.expected_units.size() != 0 && cycles < limit) begin
      @(posedge clk);
      cycles++;
    end
  endtask

  function automatic void buf_byte(logic [7:0] v);
    utf8_buf.insert(utf8_buf.size(), v);
  endfunction

  // encodes any 21-bit value in the given length, legal or not
  function automatic void append_point(logic [20:0] cp, int len);
    case (len)
      1: buf_byte(cp[7:0]);
      2: begin
        buf_byte({3'b110, cp[10:6]});
        buf_byte({2'b10, cp[5:0]});
      end
      3: begin
        buf_byte({4'b1110, cp[15:12]});
        buf_byte({2'b10, cp[11:6]});
        buf_byte({2'b10, cp[5:0]});
      end
      default: begin
        buf_byte({5'b11110, cp[20:18]});
        buf_byte({2'b10, cp[17:12]});
        buf_byte({2'b10, cp[11:6]});
        buf_byte({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  task automatic send_string(input bit broken);
    int          points;
    int          flaw_at;
    int          kind;
    logic [20:0] cp;
    utf8_buf.delete();
    points  = $urandom_range(1, 6);
    flaw_at = broken ? $urandom_range(0, points) : -1;
    for (int i = 0; i <= points; i++) begin
      if (i == flaw_at) begin
        case ($urandom_range(0, 5))
          0: buf_byte(8'($urandom_range(0, 255)));
          1: buf_byte(8'($urandom_range(8'hC0, 8'hF7)));
          2: buf_byte(8'($urandom_range(8'h80, 8'hBF)));
          3: begin
            kind = $urandom_range(2, 4);
            if (kind == 2) append_point(21'($urandom_range(0, 16'h7F)), 2);
            else if (kind == 3) append_point(21'($urandom_range(0, 16'h7FF)), 3);
            else append_point(21'($urandom_range(0, 16'hFFFF)), 4);
          end
          4: append_point(21'($urandom_range(16'hD800, 16'hDFFF)), 3);
          default: append_point(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4);
        endcase
      end
      if (i < points) begin
        kind = $urandom_range(0, 9);
        if (kind < 4) begin
          append_point(21'($urandom_range(0, 16'h7F)), 1);
        end else if (kind < 6) begin
          append_point(21'($urandom_range(16'h80, 16'h7FF)), 2);
        end else if (kind < 8) begin
          cp = 21'($urandom_range(16'h800, 16'hFFFF));
          if (cp >= SurrLow && cp <= SurrHigh) cp = cp ^ 21'h002000;
          append_point(cp, 3);
        end else begin
          append_point(21'($urandom_range(21'h010000, 21'h10FFFF)), 4);
        end
      end
    end
    foreach (utf8_buf[i]) push_byte(utf8_buf[i], i == utf8_buf.size() - 1);
  endtask

  task automatic random_traffic(input int target);
    int pick;
    while (live_bytes < target) begin
      pick = $urandom_range(0, 19);
      if (pick < 15) begin
        send_string(1'b0);
      end else if (pick < 18) begin
        send_string(1'b1);
      end else begin
        repeat ($urandom_range(1, 4))
          push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end
    end
  endtask

  // receiver: random back-pressure, plus a long hold-off when asked
  initial begin
    int holds_done;
    int hold_left;
    holds_done      = 0;
    hold_left       = 0;
    unit_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done < hold_requests) begin
        holds_done++;
        hold_left = 60;
      end
      if (hold_left > 0) begin
        hold_left--;
        unit_chan.ready <= 1'b0;
      end else if (!receiver_gaps) begin
        unit_chan.ready <= 1'b1;
      end else begin
        unit_chan.ready <= ($urandom_range(0, 99) >= 33);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && unit_chan.valid && unit_chan.ready)
      sb.check_unit(unit_chan.unit_out, unit_chan.end_of_string);
  end

  initial begin
    rst                  = 1'b1;
    byte_chan.valid      = 1'b0;
    byte_chan.byte_in    = 8'h00;
    byte_chan.final_byte = 1'b0;
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (DirectedSeq[i]) push_byte(DirectedSeq[i][7:0], DirectedSeq[i][8]);
    wait_drain(2000);

    random_traffic(130);

    // sink stalls while the source keeps requests coming
    sender_gaps = 1'b0;
    hold_requests++;
    random_traffic(175);
    sender_gaps = 1'b1;

    sender_gaps   = 1'b0;
    receiver_gaps = 1'b0;
    random_traffic(245);
    sender_gaps   = 1'b1;
    receiver_gaps = 1'b1;

    random_traffic(362);

    wait_drain(2000);
    repeat (20) @(posedge clk);
    if (sb.expected_units.size() != 0) begin
      $display("%0t: %0d expected units never arrived", $time, sb.expected_units.size());
      sb.errors += sb.expected_units.size();
    end
    if (sb.errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
